>>> hdl/cnnt_pkg.sv
package cnnt_pkg;

    localparam int MAX_POINTS_DEF = 128;
    localparam int COORD_BITS_DEF = 16;

    localparam int MODE_W  = 5;
    localparam int COUNT_W = 8;
    localparam int VALUE_W = 33;
    localparam int SQ_W    = 32;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // mode codes
    localparam logic [MODE_W-1:0] M_SQ1      = 5'd0;
    localparam logic [MODE_W-1:0] M_R1       = 5'd1;
    localparam logic [MODE_W-1:0] M_RSUM     = 5'd2;
    localparam logic [MODE_W-1:0] M_SQSUM    = 5'd3;
    localparam logic [MODE_W-1:0] M_RADD     = 5'd4;
    localparam logic [MODE_W-1:0] M_SQMUL    = 5'd5;
    localparam logic [MODE_W-1:0] M_RMUL     = 5'd6;
    localparam logic [MODE_W-1:0] M_NSQ1     = 5'd7;
    localparam logic [MODE_W-1:0] M_NR1      = 5'd8;
    localparam logic [MODE_W-1:0] M_IRSUM    = 5'd9;
    localparam logic [MODE_W-1:0] M_ISQSUM   = 5'd10;
    localparam logic [MODE_W-1:0] M_IRADD    = 5'd11;
    localparam logic [MODE_W-1:0] M_ISQMUL   = 5'd12;
    localparam logic [MODE_W-1:0] M_IRMUL    = 5'd13;
    localparam logic [MODE_W-1:0] M_SQDIF    = 5'd14;
    localparam logic [MODE_W-1:0] M_RDIF     = 5'd15;
    localparam logic [MODE_W-1:0] M_RSUB     = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT_SET,
        S_ROOT,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_FORM,
        S_OUT
    } t_state;

endpackage

>>> hdl/cnnt_ram.sv
module cnnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/cellular_noise_nearest_two.sv
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     opcode, point_index, coord_x, coord_y
// m_axis    out  m_axis_tvalid/tready     value, nearest_sq, second_sq
// cfg       in   i_cfg_we (no wait)       mode, point_count
// A query scans point_count points (2..MAX_POINTS), one per cycle, then passes a drain
// state, then 2 or 3 root passes on one shared root unit, the states MUL_A to MUL_D on
// one 33x17 multiplier and a form state.
// Reset (synchronous, active low) clears control only; the table is undefined.
// The input side is not ready while a query is in work or its result waits.
module cellular_noise_nearest_two #(
    parameter int MAX_POINTS = cnnt_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] opcode, [7:1] point_index, [23:8] coord_x, [39:24] coord_y
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [32:0] value, [64:33] nearest_sq, [96:65] second_sq, zero fill
    output logic [103:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    localparam int COORD_BITS = cnnt_pkg::COORD_BITS_DEF;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SH_DOWN = (2 * COORD_BITS > 32) ? (2 * COORD_BITS - 32) : 0;
    localparam int SH_UP   = (2 * COORD_BITS < 32) ? (32 - 2 * COORD_BITS) : 0;

    // input fields
    logic        in_op;
    logic [6:0]  in_idx;
    logic [15:0] in_x, in_y;
    assign in_op  = s_axis_tdata[0];
    assign in_idx = s_axis_tdata[7:1];
    assign in_x   = s_axis_tdata[23:8];
    assign in_y   = s_axis_tdata[39:24];

    // configuration
    logic [4:0] r_mode;
    logic [7:0] r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 5'd0;
            r_count <= 8'd20;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cnnt_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data[4:0];
            end else begin
                r_count <= i_cfg_data;
            end
        end
    end

    cnnt_pkg::t_state r_state, n_state;
    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // point table
    logic            ram_we;
    logic [AW-1:0]   r_raddr;
    logic [2*COORD_BITS-1:0] ram_rd;
    assign ram_we = s_acc && (in_op == cnnt_pkg::OP_LOAD)
                    && ({25'd0, in_idx} < 32'(MAX_POINTS));
    cnnt_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata ({in_y[COORD_BITS-1:0], in_x[COORD_BITS-1:0]}),
        .i_raddr (r_raddr),
        .o_rdata (ram_rd)
    );

    // query and scan bookkeeping
    logic [COORD_BITS-1:0] r_qx, r_qy;
    logic [CW-1:0] r_n, r_ci, r_di;
    logic          r_dv;
    logic [CW-1:0] n_sat;
    always_comb begin
        if (r_count < 8'd2) begin
            n_sat = CW'(2);
        end else if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_sat = CW'(MAX_POINTS);
        end else begin
            n_sat = CW'(r_count);
        end
    end

    // distance unit
    function automatic logic [COORD_BITS-1:0] gap(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        if (d > {1'b1, {(COORD_BITS-1){1'b0}}}) begin
            d = {COORD_BITS{1'b0}} - d;
        end
        return d;
    endfunction

    logic [COORD_BITS-1:0] dx, dy;
    logic [2*COORD_BITS:0] dsum;
    logic [32:0] dsq;
    assign dx   = gap(ram_rd[COORD_BITS-1:0], r_qx);
    assign dy   = gap(ram_rd[2*COORD_BITS-1:COORD_BITS], r_qy);
    assign dsum = (2*COORD_BITS+1)'(dx) * (2*COORD_BITS+1)'(dx)
                  + (2*COORD_BITS+1)'(dy) * (2*COORD_BITS+1)'(dy);
    assign dsq  = 33'((dsum >> SH_DOWN) << SH_UP);

    logic [32:0] r_sq1, r_sq2;

    // root unit: one result bit per cycle over a 62-bit radicand
    logic [63:0] r_rv, r_rr, r_rb;
    logic [4:0]  r_rcnt;
    logic [1:0]  r_rsel;
    logic [31:0] r_root1, r_root2, r_root3;
    logic [63:0] rsum;
    assign rsum = r_rr + r_rb;

    logic [33:0] sqs, sqd;
    assign sqs = {1'b0, r_sq1} + {1'b0, r_sq2};
    assign sqd = {1'b0, r_sq2} - {1'b0, r_sq1};
    logic [33:0] rad3;
    always_comb begin
        if (r_mode == cnnt_pkg::M_RDIF) begin
            rad3 = sqd;
        end else begin
            rad3 = sqs;
        end
    end
    logic [63:0] rad_sel;
    always_comb begin
        case (r_rsel)
            2'd0:    rad_sel = 64'(r_sq1) << 28;
            2'd1:    rad_sel = 64'(r_sq2) << 28;
            default: rad_sel = 64'(rad3) << 28;
        endcase
    end

    // shared multiplier, 33x33 split into two passes over the 17-bit low and 16-bit high halves of r_mb
    logic [32:0] r_ma, r_mb;
    logic [65:0] r_prod;
    logic [49:0] mul_part;
    assign mul_part = (r_state == cnnt_pkg::S_MUL_B) ? 50'(r_ma) * 50'(r_mb[16:0])
                                                      : 50'(r_ma) * 50'(r_mb[32:17]);

    // result register
    logic [32:0] r_val;
    logic [31:0] r_o1, r_o2;
    logic        r_ov;
    logic signed [35:0] form;
    logic signed [35:0] one_q;
    logic signed [35:0] rsum2;
    assign one_q = 36'sd1 <<< 30;
    assign rsum2 = $signed(36'(r_root1)) + $signed(36'(r_root2));
    always_comb begin
        case (r_mode)
            cnnt_pkg::M_SQ1:    form = $signed(36'(r_sq1 >> 2));
            cnnt_pkg::M_R1:     form = $signed(36'(r_root1));
            cnnt_pkg::M_RSUM:   form = $signed(36'(r_root3));
            cnnt_pkg::M_SQSUM:  form = $signed(36'(sqs >> 2));
            cnnt_pkg::M_RADD:   form = rsum2;
            cnnt_pkg::M_SQMUL:  form = $signed(36'(r_prod >> 34));
            cnnt_pkg::M_RMUL:   form = $signed(36'(r_prod >> 30));
            cnnt_pkg::M_NSQ1:   form = -$signed(36'(r_sq1 >> 2));
            cnnt_pkg::M_NR1:    form = -$signed(36'(r_root1));
            cnnt_pkg::M_IRSUM:  form = one_q - $signed(36'(r_root3));
            cnnt_pkg::M_ISQSUM: form = one_q - $signed(36'(sqs >> 2));
            cnnt_pkg::M_IRADD:  form = one_q - rsum2;
            cnnt_pkg::M_ISQMUL: form = one_q - $signed(36'(r_prod >> 34));
            cnnt_pkg::M_IRMUL:  form = one_q - $signed(36'(r_prod >> 30));
            cnnt_pkg::M_SQDIF:  form = $signed(36'(sqd >> 2));
            cnnt_pkg::M_RDIF:   form = $signed(36'(r_root3));
            cnnt_pkg::M_RSUB:   form = $signed(36'(r_root2)) - $signed(36'(r_root1));
            default:            form = 36'sd0;
        endcase
    end
    logic [32:0] sat;
    always_comb begin
        if (form > 36'sd4294967295) begin
            sat = {1'b0, 32'hFFFF_FFFF};
        end else if (form < -36'sd4294967296) begin
            sat = {1'b1, 32'd0};
        end else begin
            sat = form[32:0];
        end
    end

    logic root3_needed;
    assign root3_needed = (r_mode == cnnt_pkg::M_RSUM) || (r_mode == cnnt_pkg::M_IRSUM)
                          || (r_mode == cnnt_pkg::M_RDIF);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cnnt_pkg::S_IDLE: begin
                if (s_acc && in_op == cnnt_pkg::OP_QUERY) n_state = cnnt_pkg::S_SCAN;
            end
            cnnt_pkg::S_SCAN:  if (r_ci == r_n - CW'(1)) n_state = cnnt_pkg::S_DRAIN;
            cnnt_pkg::S_DRAIN: n_state = cnnt_pkg::S_ROOT_SET;
            cnnt_pkg::S_ROOT_SET: n_state = cnnt_pkg::S_ROOT;
            cnnt_pkg::S_ROOT: begin
                if (r_rcnt == 5'd0) begin
                    if (r_rsel == 2'd0 || (r_rsel == 2'd1 && root3_needed)) begin
                        n_state = cnnt_pkg::S_ROOT_SET;
                    end else begin
                        n_state = cnnt_pkg::S_MUL_A;
                    end
                end
            end
            cnnt_pkg::S_MUL_A: n_state = cnnt_pkg::S_MUL_B;
            cnnt_pkg::S_MUL_B: n_state = cnnt_pkg::S_MUL_C;
            cnnt_pkg::S_MUL_C: n_state = cnnt_pkg::S_MUL_D;
            cnnt_pkg::S_MUL_D: n_state = cnnt_pkg::S_FORM;
            cnnt_pkg::S_FORM:  n_state = cnnt_pkg::S_OUT;
            cnnt_pkg::S_OUT:   if (m_axis_tready) n_state = cnnt_pkg::S_IDLE;
            default: n_state = cnnt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == cnnt_pkg::S_IDLE);
        m_axis_tvalid = r_ov;
    end
    assign m_axis_tdata = {7'd0, r_o2, r_o1, r_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cnnt_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cnnt_pkg::S_FORM) r_ov <= 1'b1;
            else if (r_ov && m_axis_tready) r_ov <= 1'b0;
            r_dv <= (r_state == cnnt_pkg::S_SCAN);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cnnt_pkg::S_IDLE: begin
                r_qx    <= in_x[COORD_BITS-1:0];
                r_qy    <= in_y[COORD_BITS-1:0];
                r_n     <= n_sat;
                r_ci    <= CW'(0);
                r_raddr <= AW'(0);
                r_di    <= CW'(0);
                r_rsel  <= 2'd0;
            end
            cnnt_pkg::S_SCAN: begin
                r_ci    <= r_ci + CW'(1);
                r_raddr <= AW'(r_ci + CW'(1));
            end
            cnnt_pkg::S_ROOT_SET: begin
                r_rv   <= rad_sel;
                r_rr   <= 64'd0;
                r_rb   <= 64'd1 << 62;
                r_rcnt <= 5'd31;
            end
            cnnt_pkg::S_ROOT: begin
                if (r_rv >= rsum) begin
                    r_rv <= r_rv - rsum;
                    r_rr <= (r_rr >> 1) + r_rb;
                end else begin
                    r_rr <= r_rr >> 1;
                end
                r_rb   <= r_rb >> 2;
                r_rcnt <= r_rcnt - 5'd1;
                if (r_rcnt == 5'd0) begin
                    r_rsel <= r_rsel + 2'd1;
                    if (r_rv >= rsum) begin
                        case (r_rsel)
                            2'd0:    r_root1 <= 32'((r_rr >> 1) + r_rb);
                            2'd1:    r_root2 <= 32'((r_rr >> 1) + r_rb);
                            default: r_root3 <= 32'((r_rr >> 1) + r_rb);
                        endcase
                    end else begin
                        case (r_rsel)
                            2'd0:    r_root1 <= 32'(r_rr >> 1);
                            2'd1:    r_root2 <= 32'(r_rr >> 1);
                            default: r_root3 <= 32'(r_rr >> 1);
                        endcase
                    end
                end
            end
            cnnt_pkg::S_MUL_A: begin
                if (r_mode == cnnt_pkg::M_SQMUL || r_mode == cnnt_pkg::M_ISQMUL) begin
                    r_ma <= r_sq1;
                    r_mb <= r_sq2;
                end else begin
                    r_ma <= {1'b0, r_root1};
                    r_mb <= {1'b0, r_root2};
                end
            end
            cnnt_pkg::S_MUL_B: r_prod <= 66'(mul_part);
            cnnt_pkg::S_MUL_C: r_prod <= r_prod + (66'(mul_part) << 17);
            cnnt_pkg::S_FORM: begin
                r_val <= sat;
                r_o1  <= r_sq1[31:0];
                r_o2  <= r_sq2[31:0];
            end
            default: begin
            end
        endcase
        // compare stage, one distance per cycle behind the read
        if (r_dv) begin
            r_di <= r_di + CW'(1);
            if (r_di == CW'(0)) begin
                r_sq1 <= dsq;
                r_sq2 <= 33'd0;
            end else if (dsq < r_sq1) begin
                r_sq2 <= r_sq1;
                r_sq1 <= dsq;
            end else if (r_di == CW'(1) || dsq < r_sq2) begin
                r_sq2 <= dsq;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cnnt_pkg::S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cnnt_pkg::S_FORM) |-> (r_sq2 >= r_sq1))
        else $error("second nearest below nearest");
    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && in_op == cnnt_pkg::OP_LOAD) |=> (r_state == cnnt_pkg::S_IDLE))
        else $error("load started a search");
`endif
endmodule
